FILE: rtl/llpf_pkg.sv
package llpf_pkg;

    localparam int LIGHT_W     = 12;
    localparam int PCT_W       = 7;
    localparam int WEIGHT_W    = 16;
    localparam int Q_BITS      = 16;
    localparam int LEVEL_W     = LIGHT_W + Q_BITS;      // Q12.16
    localparam int MUL_A_W     = WEIGHT_W + 1;          // holds 65536 - w
    localparam int PROD_W      = MUL_A_W + LEVEL_W;
    localparam int PCT_NUM_W   = 19;                    // 4095 * 100 < 2^19
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    localparam int SAMPLES_PER_AVERAGE_DEF = 16;

    localparam logic [LIGHT_W-1:0]  DARK_RESET   = 12'd2000;
    localparam logic [LIGHT_W-1:0]  BRIGHT_RESET = 12'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 28'(1000) << Q_BITS;
    localparam logic [MUL_A_W-1:0]  WEIGHT_ONE   = 17'h1_0000;
    localparam int                  PCT_SCALE    = 100;
    localparam int                  PCT_MAX      = 100;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_DARK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_NEW,
        MUL_OLD,
        MUL_PCT
    } mul_op_t;

    typedef struct packed {
        logic     accumulate;
        logic     div_start;
        mul_op_t  mul_op;
        logic     update_level;
        logic     zero_pct;
        logic     load_pct;
        logic     load_out;
    } llpf_cmd_t;

    typedef struct packed {
        logic block_done;
        logic div_busy;
        logic div_done;
        logic pct_skip;
        logic out_free;
    } llpf_status_t;

endpackage

FILE: rtl/llpf_div.sv
module llpf_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/llpf_datapath.sv
module llpf_datapath #(
    parameter int SAMPLES_PER_AVERAGE = llpf_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [llpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [llpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [llpf_pkg::LIGHT_W-1:0]     s_light_sample,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [llpf_pkg::PCT_W-1:0]       m_light_percent,
    output logic [llpf_pkg::LIGHT_W-1:0]     m_filtered_reading,
    output logic                             m_range_error,
    input  llpf_pkg::llpf_cmd_t              cmd,
    output llpf_pkg::llpf_status_t           status
);

    import llpf_pkg::*;

    localparam int CNT_W      = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SUM_W      = LIGHT_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int DVD_W      = PCT_NUM_W;
    localparam int DVS_W      = LIGHT_W;
    // mean by reciprocal: floor(sum / N) = (sum * ceil(2^S / N)) >> S, S = SUM_W + clog2(N)
    localparam int MEAN_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RECIP_W    = SUM_W + 1;
    localparam int MPROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    logic [LIGHT_W-1:0]  dark_reg;
    logic [LIGHT_W-1:0]  bright_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [LIGHT_W-1:0]  mean_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  new_part_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic                out_valid_reg;
    logic [PCT_W-1:0]    out_pct_reg;
    logic [LIGHT_W-1:0]  out_level_reg;
    logic                out_err_reg;

    logic [SUM_W-1:0]    sum_base;
    logic [SUM_W-1:0]    sum_plus;
    logic [MPROD_W-1:0]  mean_prod;
    logic [LIGHT_W-1:0]  level_int;
    logic [LIGHT_W-1:0]  dark_minus_level;
    logic                range_bad;
    logic [MUL_A_W-1:0]  mul_a;
    logic [LEVEL_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod_next;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    div_quo;
    logic                div_busy;
    logic                div_done;
    logic                out_free;

    // sum_reg keeps the finished block until the first word of the next one
    assign sum_base         = (count_reg == '0) ? '0 : sum_reg;
    assign sum_plus         = sum_base + SUM_W'(s_light_sample);
    assign mean_prod        = MPROD_W'(sum_reg) * MPROD_W'(MEAN_RECIP);
    assign level_int        = level_reg[LEVEL_W-1:Q_BITS];
    assign dark_minus_level = dark_reg - level_int;
    assign range_bad        = !(dark_reg > bright_reg);
    assign out_free         = !out_valid_reg || m_tready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_NEW: begin
                mul_a = {1'b0, weight_reg};
                mul_b = LEVEL_W'(mean_reg);
            end
            MUL_OLD: begin
                mul_a = WEIGHT_ONE - {1'b0, weight_reg};
                mul_b = level_reg;
            end
            MUL_PCT: begin
                mul_a = MUL_A_W'(PCT_SCALE);
                mul_b = LEVEL_W'(dark_minus_level);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign div_dividend = prod_reg[PCT_NUM_W-1:0];
    assign div_divisor  = dark_reg - bright_reg;

    llpf_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg      <= DARK_RESET;
            bright_reg    <= BRIGHT_RESET;
            weight_reg    <= WEIGHT_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            level_reg     <= LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DARK:   dark_reg   <= cfg_data[LIGHT_W-1:0];
                    CFG_BRIGHT: bright_reg <= cfg_data[LIGHT_W-1:0];
                    CFG_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.accumulate) begin
                sum_reg <= sum_plus;
                if (status.block_done) begin
                    count_reg <= '0;
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.update_level) begin
                // w*mean already sits on the Q.16 grid; only the old part is truncated
                level_reg <= new_part_reg + prod_reg[LEVEL_W+Q_BITS-1:Q_BITS];
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mean_reg <= mean_prod[MEAN_SHIFT+LIGHT_W-1:MEAN_SHIFT];
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_op == MUL_OLD) begin
            new_part_reg <= prod_reg[LEVEL_W-1:0];
        end
        if (cmd.zero_pct) begin
            pct_reg <= '0;
        end else if (cmd.load_pct) begin
            pct_reg <= (div_quo > DVD_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : div_quo[PCT_W-1:0];
        end
        if (cmd.load_out) begin
            out_pct_reg   <= pct_reg;
            out_level_reg <= level_int;
            out_err_reg   <= range_bad;
        end
    end

    always_comb begin
        status.block_done = count_reg == CNT_W'(SAMPLES_PER_AVERAGE - 1);
        status.div_busy   = div_busy;
        status.div_done   = div_done;
        status.pct_skip   = range_bad || (level_int >= dark_reg);
        status.out_free   = out_free;
    end

    assign m_tvalid           = out_valid_reg;
    assign m_light_percent    = out_pct_reg;
    assign m_filtered_reading = out_level_reg;
    assign m_range_error      = out_err_reg;

endmodule

FILE: rtl/llpf_ctrl.sv
module llpf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output llpf_pkg::llpf_cmd_t    cmd,
    input  llpf_pkg::llpf_status_t status
);

    import llpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_MUL_NEW,
        S_MUL_OLD,
        S_UPDATE,
        S_CHECK,
        S_PCT_DIV,
        S_PCT_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd.accumulate   = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.mul_op       = MUL_NONE;
        cmd.update_level = 1'b0;
        cmd.zero_pct     = 1'b0;
        cmd.load_pct     = 1'b0;
        cmd.load_out     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accumulate = 1'b1;
                    if (status.block_done) begin
                        state_next = S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                // mean register loads from the finished block sum
                state_next = S_MUL_NEW;
            end
            S_MUL_NEW: begin
                cmd.mul_op = MUL_NEW;
                state_next = S_MUL_OLD;
            end
            S_MUL_OLD: begin
                cmd.mul_op = MUL_OLD;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update_level = 1'b1;
                state_next       = S_CHECK;
            end
            S_CHECK: begin
                if (status.pct_skip) begin
                    cmd.zero_pct = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.mul_op = MUL_PCT;
                    state_next = S_PCT_DIV;
                end
            end
            S_PCT_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_PCT_WAIT;
            end
            S_PCT_WAIT: begin
                if (status.div_done) begin
                    cmd.load_pct = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result register overwritten while pending");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    a_block_starts_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accumulate && status.block_done) |=> (state_reg == S_MEAN))
        else $error("completed block did not start the result sequence");

    a_done_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_PCT_WAIT))
        else $error("divider finished outside the wait state");

endmodule

FILE: rtl/light_level_percent_filter_top.sv
// Channel   Dir   Handshake            Payload
// s_        in    s_tvalid/s_tready    tdata[11:0] light_sample
// m_        out   m_tvalid/m_tready    tdata[6:0] light_percent, [18:7] filtered_reading;
//                                      tuser[0] range_error
// cfg_      in    cfg_valid/cfg_ready  cfg_index (0 dark, 1 bright, 2 weight), cfg_data
//
// While idle s_tready is high; the sample that closes a block of SAMPLES_PER_AVERAGE
// starts the result sequence: mean by reciprocal multiply, two passes through the
// shared multiplier, filter update, range check (with the percent product from the
// same multiplier), percent division start and wait on the bit-serial divider, output
// load, all with s_tready low; a failed check forces the percent to zero instead.
// Reset (aresetn low, synchronous) loads register defaults and the filter start level.
// A pending result holds in the output register; the next block waits only if it
// finishes before that word is taken. cfg_ready is always high.
module light_level_percent_filter_top #(
    parameter int SAMPLES_PER_AVERAGE = llpf_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input samples
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [llpf_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] light_sample
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [llpf_pkg::M_TDATA_W-1:0]   m_tdata,   // [6:0] light_percent, [18:7] filtered_reading
    output logic                             m_tuser,   // [0] range_error
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [llpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [llpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import llpf_pkg::*;

    llpf_cmd_t          cmd;
    llpf_status_t       status;
    logic [PCT_W-1:0]   light_percent;
    logic [LIGHT_W-1:0] filtered_reading;
    logic               range_error;

    // the user must change registers only while idle; the block does not enforce it and never stalls writes
    assign cfg_ready = 1'b1;

    llpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    llpf_datapath #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_light_sample     (s_tdata[LIGHT_W-1:0]),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .m_light_percent    (light_percent),
        .m_filtered_reading (filtered_reading),
        .m_range_error      (range_error),
        .cmd                (cmd),
        .status             (status)
    );

    // word layout: percent low, filter reading above, zero fill to three bytes
    assign m_tdata = {{(M_TDATA_W - PCT_W - LIGHT_W){1'b0}}, filtered_reading, light_percent};
    assign m_tuser = range_error;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import llpf_pkg::*;

    // --------------------------------------------------------------------
    // Run constants
    // --------------------------------------------------------------------
    localparam int SAMPLES       = SAMPLES_PER_AVERAGE_DEF;
    localparam int TOTAL_SAMPLES = 1150;  // stimulus stops once this many words are in
    localparam int MAX_PAUSE     = 8;     // longest idle draw on either side
    localparam int SETTLE_CYCLES = 80;    // covers the result sequence after the closing word
    localparam int DRAIN_CYCLES  = 120;   // quiet window at the end, catches stray words
    localparam int HOLD_CYCLES   = 400;   // one long receiver hold-off
    // Slowest correct run: ~1150 words, each behind the longest idle draw, plus ~80
    // results, each with its compute and the longest stall, ~40 settle windows and
    // the hold-off. The guard below is many times that.
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, write dropped
    localparam logic [LIGHT_W-1:0]   RAIL_HI   = 12'hFFF;
    localparam logic [LIGHT_W-1:0]   RAIL_LO   = 12'h000;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX = 16'hFFFF;

    typedef enum int unsigned {
        BLK_UNIFORM,  // every word drawn over the full range
        BLK_FLAT,     // one value repeated
        BLK_RAILS,    // each word at 0 or full scale
        BLK_CLUSTER   // small spread around one value
    } block_style_t;

    typedef struct packed {
        logic [PCT_W-1:0]   percent;
        logic [LIGHT_W-1:0] reading;
        logic               range_err;
    } light_result_t;

    // --------------------------------------------------------------------
    // Scoreboard: own copy of the registers and filter state, a queue of
    // expected result words, and the field-by-field compare.
    // --------------------------------------------------------------------
    class light_scoreboard;
        logic [LIGHT_W-1:0]  dark;
        logic [LIGHT_W-1:0]  bright;
        logic [WEIGHT_W-1:0] weight;
        int unsigned         block_sum;
        int unsigned         block_count;
        logic [LEVEL_W-1:0]  level;      // Q12.16 smoothed reading
        light_result_t       expected_q[$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         words_in;

        function new();
            dark        = DARK_RESET;
            bright      = BRIGHT_RESET;
            weight      = WEIGHT_RESET;
            block_sum   = 0;
            block_count = 0;
            level       = LEVEL_RESET;
            errors      = 0;
            checked     = 0;
            words_in    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DARK:   dark   = data[LIGHT_W-1:0];
                CFG_BRIGHT: bright = data[LIGHT_W-1:0];
                CFG_WEIGHT: weight = data[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulate one word; the word that closes a block yields a result.
        function void note_sample(logic [LIGHT_W-1:0] raw);
            logic [63:0]        blend;
            int unsigned        mean;
            int unsigned        span;
            int unsigned        pct;
            light_result_t      res;
            words_in++;
            block_sum += raw;
            block_count++;
            if (block_count < SAMPLES)
                return;
            mean        = block_sum / SAMPLES;
            block_sum   = 0;
            block_count = 0;
            blend = 64'(weight) * (64'(mean) << Q_BITS)
                  + (64'(WEIGHT_ONE) - 64'(weight)) * 64'(level);
            level = LEVEL_W'(blend >> Q_BITS);
            res.reading = level[LEVEL_W-1:Q_BITS];
            if (!(dark > bright)) begin
                res.percent   = '0;
                res.range_err = 1'b1;
            end else begin
                res.range_err = 1'b0;
                if (res.reading >= dark) begin
                    pct = 0;
                end else begin
                    span = dark - bright;
                    pct  = ((dark - res.reading) * PCT_SCALE) / span;
                    if (pct > PCT_MAX)
                        pct = PCT_MAX;
                end
                res.percent = PCT_W'(pct);
            end
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            light_result_t want;
            logic [PCT_W-1:0]   got_pct;
            logic [LIGHT_W-1:0] got_reading;
            got_pct     = tdata[PCT_W-1:0];
            got_reading = tdata[PCT_W+LIGHT_W-1:PCT_W];
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result word pct=%0d reading=%0d err=%0b",
                                 got_pct, got_reading, tuser));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got_pct !== want.percent)
                report($sformatf("result %0d light_percent %0d, want %0d",
                                 checked, got_pct, want.percent));
            if (got_reading !== want.reading)
                report($sformatf("result %0d filtered_reading %0d, want %0d",
                                 checked, got_reading, want.reading));
            if (tuser !== want.range_err)
                report($sformatf("result %0d range_error %0b, want %0b",
                                 checked, tuser, want.range_err));
        endtask
    endclass

    // --------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // --------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [11:0] light_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [6:0] light_percent, [18:7] filtered_reading
    logic                  m_tuser;          // [0] range_error
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DARK;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    light_scoreboard sb;

    bit          tx_idle       = 1'b1;  // sender inserts random gaps
    bit          rx_idle       = 1'b1;  // receiver inserts random stalls
    bit          hold_trigger  = 1'b0;
    logic        hold_results  = 1'b0;
    int unsigned rx_gap        = 0;
    int unsigned reg_writes    = 0;

    light_level_percent_filter_top #(
        .SAMPLES_PER_AVERAGE(SAMPLES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop, independent of the stimulus thread.
    initial begin
        #(TIMEOUT_NS * 1ns);
        $display("tb_top: FAIL");
        $finish;
    end

    // --------------------------------------------------------------------
    // Receiver: random stall before taking each word; the hold-off process
    // below can force m_tready low for a long stretch.
    // --------------------------------------------------------------------
    always @(posedge aclk) begin : result_sink
        int unsigned pause;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (hold_results) begin
            m_tready <= 1'b0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                // word taken at this edge; draw the stall before the next one
                pause = rx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
                if (pause != 0) begin
                    m_tready <= 1'b0;
                    rx_gap   <= pause - 1;
                end
            end
        end else if (rx_gap == 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_gap <= rx_gap - 1;
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Long receiver hold-off, counted here so the sender keeps offering words
    // and the block backs up into s_tready.
    initial begin : hold_off
        wait (hold_trigger);
        @(posedge aclk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_results <= 1'b0;
    end

    // --------------------------------------------------------------------
    // Driver tasks
    // --------------------------------------------------------------------
    task automatic send_sample(logic [LIGHT_W-1:0] raw);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(raw);
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(raw);
    endtask

    task automatic send_flat(int unsigned len, logic [LIGHT_W-1:0] raw);
        repeat (len) send_sample(raw);
    endtask

    task automatic send_block(int unsigned len, block_style_t style);
        int unsigned base;
        int          v;
        base = $urandom_range(0, 4095);
        for (int unsigned i = 0; i < len; i++) begin
            case (style)
                BLK_UNIFORM: v = $urandom_range(0, 4095);
                BLK_FLAT:    v = base;
                BLK_RAILS:   v = $urandom_range(0, 1) ? RAIL_HI : RAIL_LO;
                default: begin
                    v = int'(base) + int'($urandom_range(0, 64)) - 32;
                    if (v < 0)
                        v = 0;
                    if (v > 4095)
                        v = 4095;
                end
            endcase
            send_sample(LIGHT_W'(v));
        end
    endtask

    task automatic send_run(int unsigned count);
        int unsigned len;
        while (count > 0) begin
            len = (count > SAMPLES) ? SAMPLES : count;
            send_block(len, block_style_t'($urandom_range(0, 3)));
            count -= len;
        end
    endtask

    // One register write; valid drops for a cycle after each word.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Let every expected word out, then wait out SETTLE_CYCLES before touching
    // the registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [LIGHT_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return RAIL_LO;
            1:       return RAIL_HI;
            default: return LIGHT_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 15))
            0:       return '0;            // filter frozen
            1:       return 16'd1;
            2, 3:    return WEIGHT_MAX;    // follows the mean almost fully
            4, 5, 6: return WEIGHT_W'($urandom_range(32768, 65535));
            default: return WEIGHT_W'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic shuffle_config();
        logic [LIGHT_W-1:0] a;
        logic [LIGHT_W-1:0] b;
        logic [3:0]         junk;
        a    = pick_level();
        b    = pick_level();
        junk = 4'($urandom);
        // mostly a usable span; sometimes inverted or equal to hit the error flag
        if ($urandom_range(0, 4) != 0 && a < b) begin
            a = a ^ b;
            b = a ^ b;
            a = a ^ b;
        end
        if ($urandom_range(0, 9) == 0)
            b = a;
        // spare upper bits of cfg_data must be ignored for the 12-bit levels
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_DARK, {($urandom_range(0, 3) == 0) ? junk : 4'h0, a});
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_BRIGHT, {($urandom_range(0, 3) == 0) ? ~junk : 4'h0, b});
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_WEIGHT, pick_weight());
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase_len;
        int unsigned phases;
        phases = 0;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: defaults first, with every data bit toggled.
        for (int i = 0; i < SAMPLES; i++)
            send_sample(i[0] ? RAIL_HI : RAIL_LO);
        for (int i = 0; i < SAMPLES; i++)
            send_sample(i[0] ? 12'hAAA : 12'h555);

        // Widest span, fastest filter: drive the level to both rails.
        settle();
        write_reg(CFG_WEIGHT, WEIGHT_MAX);
        write_reg(CFG_DARK, CFG_DATA_W'(RAIL_HI));
        write_reg(CFG_BRIGHT, CFG_DATA_W'(RAIL_LO));
        send_flat(SAMPLES, RAIL_HI);
        send_flat(SAMPLES, RAIL_LO);

        // Inverted span flags an error; unmapped index must change nothing.
        settle();
        write_reg(CFG_DARK, 16'd1000);
        write_reg(CFG_BRIGHT, 16'd3000);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_block(SAMPLES, BLK_UNIFORM);

        // Equal levels are also an error.
        settle();
        write_reg(CFG_DARK, 16'd2048);
        write_reg(CFG_BRIGHT, 16'd2048);
        send_block(SAMPLES, BLK_FLAT);

        // Zero weight holds the filter whatever comes in.
        settle();
        write_reg(CFG_WEIGHT, '0);
        write_reg(CFG_DARK, 16'd3000);
        write_reg(CFG_BRIGHT, 16'd500);
        send_flat(SAMPLES, RAIL_HI);

        // Saturation past bright, then past dark.
        settle();
        write_reg(CFG_WEIGHT, WEIGHT_MAX);
        write_reg(CFG_DARK, 16'd2000);
        write_reg(CFG_BRIGHT, 16'd1000);
        send_flat(SAMPLES, 12'd500);
        send_flat(SAMPLES, 12'd3000);

        // Back-pressure: receiver holds off while the sender streams flat out.
        settle();
        tx_idle      = 1'b0;
        hold_trigger = 1'b1;
        send_run(4 * SAMPLES);

        // Random phases: fresh registers each time, mixed idling, with the
        // odd partial block carried over into the next phase.
        while (sb.words_in < TOTAL_SAMPLES) begin
            settle();
            shuffle_config();
            tx_idle   = ($urandom_range(0, 3) != 0);
            rx_idle   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(1, 6) * SAMPLES;
            if ($urandom_range(0, 3) == 0)
                phase_len += $urandom_range(1, SAMPLES - 1);
            send_run(phase_len);
            phases++;
        end

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d samples over %0d random phases, %0d results compared",
                 sb.words_in, phases, sb.checked);
        $display("tb_top: %0d register writes incl. rails, zero weight and inverted spans",
                 reg_writes);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
